// ===== rtl/core/pfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, letter codes and square helpers shared by the playfair encryptor.
// ----------------------------------------------------------------------------
package pfe_pkg;

  // letter code, A=0 .. Z=25
  typedef logic [4:0] letter_t;
  // square cell number, row*5+col
  typedef logic [4:0] cell_t;
  // row or column inside the square
  typedef logic [2:0] coord_t;

  // kind of an input transaction
  typedef enum logic [1:0] {
    REQ_KEY     = 2'd0,
    REQ_KEY_END = 2'd1,
    REQ_TEXT    = 2'd2,
    REQ_MSG_END = 2'd3
  } req_t;

  // memory depths
  localparam int SQ_DEPTH     = 25;
  localparam int LETTER_DEPTH = 26;

  // letter codes with a special role
  localparam letter_t LET_I     = 5'd8;
  localparam letter_t LET_J     = 5'd9;
  localparam letter_t LET_X     = 5'd23;
  localparam letter_t LET_Y     = 5'd24;
  localparam letter_t LET_LIMIT = 5'd26;
  localparam letter_t LET_LAST  = 5'd25;

  // square geometry
  localparam cell_t  FILL_LIMIT = 5'd25;
  localparam coord_t SIDE_LAST  = 3'd4;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } place_t;

  // commands from the controller to the square memories
  typedef struct packed {
    logic    wr_en;
    cell_t   wr_cell;
    letter_t wr_letter;
    logic    pl_rd_en;
    letter_t pl_addr_a;
    letter_t pl_addr_b;
    logic    sq_rd_en;
    cell_t   sq_addr_a;
    cell_t   sq_addr_b;
  } store_cmd_t;

  // registered read data of the square memories
  typedef struct packed {
    cell_t   pl_data_a;
    cell_t   pl_data_b;
    letter_t sq_data_a;
    letter_t sq_data_b;
  } store_rsp_t;

  // one encrypted pair
  typedef struct packed {
    letter_t first;
    letter_t second;
  } pair_t;

  // cell number into row and column, (p/5)%5 and p%5 by range compares
  function automatic place_t split_place(cell_t p);
    place_t res;
    if (p >= 5'd30) begin
      res.row = 3'd1;
      res.col = 3'(p - 5'd30);
    end else if (p >= 5'd25) begin
      res.row = 3'd0;
      res.col = 3'(p - 5'd25);
    end else if (p >= 5'd20) begin
      res.row = 3'd4;
      res.col = 3'(p - 5'd20);
    end else if (p >= 5'd15) begin
      res.row = 3'd3;
      res.col = 3'(p - 5'd15);
    end else if (p >= 5'd10) begin
      res.row = 3'd2;
      res.col = 3'(p - 5'd10);
    end else if (p >= 5'd5) begin
      res.row = 3'd1;
      res.col = 3'(p - 5'd5);
    end else begin
      res.row = 3'd0;
      res.col = 3'(p);
    end
    return res;
  endfunction

  // step one place right or down with wrap
  function automatic coord_t next_coord(coord_t v);
    return (v >= SIDE_LAST) ? 3'd0 : 3'(v + 3'd1);
  endfunction

  // row and column back into a cell number
  function automatic cell_t cell_index(place_t p);
    return ({2'b00, p.row} << 2) + {2'b00, p.row} + {2'b00, p.col};
  endfunction

endpackage

// ===== rtl/core/pfe_store.sv =====
// ----------------------------------------------------------------------------
// pfe_store
// Square memories: cell to letter and letter to cell, one write port and two
// registered read ports each.
// ----------------------------------------------------------------------------
module pfe_store (
  input  logic                clk,
  input  pfe_pkg::store_cmd_t cmd,
  output pfe_pkg::store_rsp_t rsp
);

  pfe_pkg::letter_t sq_mem [pfe_pkg::SQ_DEPTH];
  pfe_pkg::cell_t   pl_mem [pfe_pkg::LETTER_DEPTH];

  pfe_pkg::letter_t sq_a_r;
  pfe_pkg::letter_t sq_b_r;
  pfe_pkg::cell_t   pl_a_r;
  pfe_pkg::cell_t   pl_b_r;

  // square letters by cell
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      sq_mem[cmd.wr_cell] <= cmd.wr_letter;
    end
    if (cmd.sq_rd_en) begin
      sq_a_r <= sq_mem[cmd.sq_addr_a];
      sq_b_r <= sq_mem[cmd.sq_addr_b];
    end
  end

  // cell of each letter
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      pl_mem[cmd.wr_letter] <= cmd.wr_cell;
    end
    if (cmd.pl_rd_en) begin
      pl_a_r <= pl_mem[cmd.pl_addr_a];
      pl_b_r <= pl_mem[cmd.pl_addr_b];
    end
  end

  assign rsp.pl_data_a = pl_a_r;
  assign rsp.pl_data_b = pl_b_r;
  assign rsp.sq_data_a = sq_a_r;
  assign rsp.sq_data_b = sq_b_r;

endmodule

// ===== rtl/core/pfe_obuf.sv =====
// ----------------------------------------------------------------------------
// pfe_obuf
// Output buffer: holds one encrypted pair and sends it as two transactions.
// ----------------------------------------------------------------------------
module pfe_obuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ld_valid,
  input  pfe_pkg::pair_t ld_pair,
  output logic           ld_ready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,   // [4:0] cipher_letter, [7:5] zero
  output logic           out_tlast
);

  // letters still to send: 2 both, 1 second only, 0 empty
  logic [1:0]     cnt_r;
  logic [1:0]     cnt_nxt;
  pfe_pkg::pair_t pair_r;

  assign ld_ready = (cnt_r == 2'd0);

  // count update
  always_comb begin
    cnt_nxt = cnt_r;
    if (ld_valid && ld_ready) begin
      cnt_nxt = 2'd2;
    end else if (out_tvalid && out_tready) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // pair payload
  always_ff @(posedge clk) begin
    if (ld_valid && ld_ready) begin
      pair_r <= ld_pair;
    end
  end

  // result channel
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {3'b000, (cnt_r == 2'd2) ? pair_r.first : pair_r.second};
  assign out_tlast  = (cnt_r == 2'd1);

endmodule

// ===== rtl/core/pfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfe_ctrl
// Sequencer: key placement, key-end fill sweep, text pairing and the two
// memory lookups of each pair.
// ----------------------------------------------------------------------------
module pfe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  pfe_pkg::req_t       in_req,
  input  pfe_pkg::letter_t    in_letter,
  output pfe_pkg::store_cmd_t cmd,
  input  pfe_pkg::store_rsp_t rsp,
  output logic                ld_valid,
  output pfe_pkg::pair_t      ld_pair,
  input  logic                ld_ready
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FILL  = 4'b0010,
    ST_PLACE = 4'b0100,
    ST_CELL  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [25:0]      seen_r, seen_nxt;
  pfe_pkg::cell_t   fc_r, fc_nxt;
  pfe_pkg::letter_t fill_idx_r, fill_idx_nxt;
  logic             pend_v_r, pend_v_nxt;
  pfe_pkg::letter_t pend_l_r, pend_l_nxt;
  logic             xx_r, xx_nxt;

  logic             acc;
  logic             let_ok;
  pfe_pkg::letter_t let_f;
  pfe_pkg::letter_t pair_b;
  logic             pair_go;
  pfe_pkg::place_t  pa, pb, ta, tb;

  assign in_tready = (state_r == ST_IDLE);
  assign acc       = in_tvalid && in_tready;

  // letter check and J folded into I
  assign let_ok = (in_letter < pfe_pkg::LET_LIMIT);
  assign let_f  = (in_letter == pfe_pkg::LET_J) ? pfe_pkg::LET_I : in_letter;

  // partner of the pending letter
  assign pair_b = (in_req == pfe_pkg::REQ_TEXT && let_f != pend_l_r) ? let_f : pfe_pkg::LET_X;

  // playfair rule on the looked-up places
  always_comb begin
    pa = pfe_pkg::split_place(rsp.pl_data_a);
    pb = pfe_pkg::split_place(rsp.pl_data_b);
    if (pa.row == pb.row) begin
      ta = '{row: pa.row, col: pfe_pkg::next_coord(pa.col)};
      tb = '{row: pb.row, col: pfe_pkg::next_coord(pb.col)};
    end else if (pa.col == pb.col) begin
      ta = '{row: pfe_pkg::next_coord(pa.row), col: pb.col};
      tb = '{row: pfe_pkg::next_coord(pb.row), col: pb.col};
    end else begin
      ta = '{row: pa.row, col: pb.col};
      tb = '{row: pb.row, col: pa.col};
    end
  end

  // result pair, X-X gives Y-Y
  assign ld_pair.first  = xx_r ? pfe_pkg::LET_Y : rsp.sq_data_a;
  assign ld_pair.second = xx_r ? pfe_pkg::LET_Y : rsp.sq_data_b;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    seen_nxt     = seen_r;
    fc_nxt       = fc_r;
    fill_idx_nxt = fill_idx_r;
    pend_v_nxt   = pend_v_r;
    pend_l_nxt   = pend_l_r;
    xx_nxt       = xx_r;
    cmd          = '0;
    ld_valid     = 1'b0;
    pair_go      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_req)
            pfe_pkg::REQ_KEY: begin
              if (let_ok && !seen_r[let_f] && fc_r < pfe_pkg::FILL_LIMIT) begin
                cmd.wr_en       = 1'b1;
                cmd.wr_cell     = fc_r;
                cmd.wr_letter   = let_f;
                seen_nxt[let_f] = 1'b1;
                fc_nxt          = fc_r + 5'd1;
              end
            end
            pfe_pkg::REQ_KEY_END: begin
              state_nxt    = ST_FILL;
              fill_idx_nxt = '0;
              pend_v_nxt   = 1'b0;
              pend_l_nxt   = '0;
            end
            pfe_pkg::REQ_TEXT: begin
              if (let_ok) begin
                if (!pend_v_r) begin
                  pend_v_nxt = 1'b1;
                  pend_l_nxt = let_f;
                end else begin
                  pair_go = 1'b1;
                  // a doubled letter stays pending
                  if (let_f != pend_l_r) begin
                    pend_v_nxt = 1'b0;
                    pend_l_nxt = '0;
                  end
                end
              end
            end
            pfe_pkg::REQ_MSG_END: begin
              if (pend_v_r) begin
                pair_go    = 1'b1;
                pend_v_nxt = 1'b0;
                pend_l_nxt = '0;
              end
            end
            default: ;
          endcase
          // look up both places of the pair
          if (pair_go) begin
            cmd.pl_rd_en  = 1'b1;
            cmd.pl_addr_a = pend_l_r;
            cmd.pl_addr_b = pair_b;
            xx_nxt        = (pend_l_r == pfe_pkg::LET_X) && (pair_b == pfe_pkg::LET_X);
            state_nxt     = ST_PLACE;
          end
        end
      end
      ST_FILL: begin
        // one letter a cycle in alphabetical order
        if (fill_idx_r != pfe_pkg::LET_J && !seen_r[fill_idx_r]
            && fc_r < pfe_pkg::FILL_LIMIT) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_cell   = fc_r;
          cmd.wr_letter = fill_idx_r;
          fc_nxt        = fc_r + 5'd1;
        end
        fill_idx_nxt = fill_idx_r + 5'd1;
        if (fill_idx_r == pfe_pkg::LET_LAST) begin
          seen_nxt  = '0;
          fc_nxt    = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_PLACE: begin
        cmd.sq_rd_en  = 1'b1;
        cmd.sq_addr_a = pfe_pkg::cell_index(ta);
        cmd.sq_addr_b = pfe_pkg::cell_index(tb);
        state_nxt     = ST_CELL;
      end
      ST_CELL: begin
        ld_valid = 1'b1;
        if (ld_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      seen_r     <= '0;
      fc_r       <= '0;
      fill_idx_r <= '0;
      pend_v_r   <= 1'b0;
      pend_l_r   <= '0;
      xx_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      seen_r     <= seen_nxt;
      fc_r       <= fc_nxt;
      fill_idx_r <= fill_idx_nxt;
      pend_v_r   <= pend_v_nxt;
      pend_l_r   <= pend_l_nxt;
      xx_r       <= xx_nxt;
    end
  end

  // square never holds more than 25 letters
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= pfe_pkg::FILL_LIMIT)
    else $error("fill count beyond square size");

  // end of the fill sweep leaves a fresh key state
  a_fill_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL && fill_idx_r == pfe_pkg::LET_LAST)
    |=> (state_r == ST_IDLE && fc_r == '0 && seen_r == '0))
    else $error("key state not cleared after fill");

  // writes and lookups never share a cycle, so no forwarding is needed
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_en && (cmd.pl_rd_en || cmd.sq_rd_en)))
    else $error("memory write during lookup");

  // square read data holds while the output buffer is busy
  a_cell_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_valid && !ld_ready)
    |=> (state_r == ST_CELL && $stable(rsp.sq_data_a) && $stable(rsp.sq_data_b)))
    else $error("square data lost during stall");

endmodule

// ===== rtl/core/playfair_encryptor.sv =====
// ----------------------------------------------------------------------------
// playfair_encryptor
// Playfair cipher: builds a 5x5 key square and encrypts text letter pairs.
// ----------------------------------------------------------------------------
// Input channel: in_tuser carries the kind (key letter, key end, text letter,
// message end), in_tdata[4:0] the letter (A=0 .. Z=25). Result channel:
// out_tdata[4:0] carries a cipher letter, out_tlast marks the second letter
// of each pair. A pair is sent as two transactions.
// New key letters are written into the square on acceptance; text letters that
// only become pending are held. A key end starts a sweep over all 26 letters
// that fills the rest of the square in alphabetical order, skipping J.
// An item that completes a pair goes through a place lookup in the
// letter-to-cell memory, a letter lookup in the cell-to-letter memory, then a
// load into the output buffer, from whose register its first result is sent.
// Both memories have a registered read.
// When the receiver stalls, the buffered pair waits in the output buffer and
// the next item is still taken; a further pair waits in the lookup stage
// until the buffer is free, with in_tready low.
// Reset clears the key state, the pending letter and the output buffer; the
// square memories hold no valid data until a key end has completed.
// ----------------------------------------------------------------------------
module playfair_encryptor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [4:0] letter, [7:5] zero
  input  logic [1:0] in_tuser,   // [1:0] req_type
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [4:0] cipher_letter, [7:5] zero
  output logic       out_tlast
);

  pfe_pkg::store_cmd_t cmd;
  pfe_pkg::store_rsp_t rsp;
  pfe_pkg::pair_t      ld_pair;
  logic                ld_valid;
  logic                ld_ready;
  pfe_pkg::req_t       in_req;

  assign in_req = pfe_pkg::req_t'(in_tuser);

  // pairing and lookup sequencer
  pfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_req    (in_req),
    .in_letter (in_tdata[4:0]),
    .cmd       (cmd),
    .rsp       (rsp),
    .ld_valid  (ld_valid),
    .ld_pair   (ld_pair),
    .ld_ready  (ld_ready)
  );

  // key square memories
  pfe_store u_store (
    .clk (clk),
    .cmd (cmd),
    .rsp (rsp)
  );

  // result buffer
  pfe_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld_valid   (ld_valid),
    .ld_pair    (ld_pair),
    .ld_ready   (ld_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
